[hdl/trainer_telemetry_decoder_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the trainer telemetry decoder
// checks sampled on the rising edge of clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TRAINER_TELEMETRY_DECODER_ASSERT_SVH
`define TRAINER_TELEMETRY_DECODER_ASSERT_SVH

// same-cycle implication
`define TTD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ttd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg
// shared constants, types and divide-by-constant factors of the decoder
// ----------------------------------------------------------------------------
package ttd_pkg;

	localparam int HISTORY_DEPTH    = 10;
	localparam int MESSAGE_BYTES    = 64;
	localparam int POS_W            = $clog2(MESSAGE_BYTES + 1);
	localparam int HIST_IDX_W       = $clog2(HISTORY_DEPTH);

	localparam int CONTROLLER_BYTES = 24;
	localparam int BRAKE_BYTES      = 48;

	// byte offsets inside a message
	localparam logic [POS_W-1:0] POS_HR      = POS_W'(12);
	localparam logic [POS_W-1:0] POS_BTN     = POS_W'(13);
	localparam logic [POS_W-1:0] POS_STEER_L = POS_W'(18);
	localparam logic [POS_W-1:0] POS_STEER_H = POS_W'(19);
	localparam logic [POS_W-1:0] POS_SPD_L   = POS_W'(32);
	localparam logic [POS_W-1:0] POS_SPD_H   = POS_W'(33);
	localparam logic [POS_W-1:0] POS_PWR_L   = POS_W'(38);
	localparam logic [POS_W-1:0] POS_PWR_H   = POS_W'(39);
	localparam logic [POS_W-1:0] POS_CAD     = POS_W'(44);
	localparam logic [POS_W-1:0] POS_PEDAL   = POS_W'(46);

	// power: positive raw / 13 as multiply by reciprocal
	localparam int POWER_DIVISOR = 13;
	localparam int PW_W          = 12;
	localparam int PW_MAX        = 32767 / POWER_DIVISOR;
	localparam int PW_SHIFT      = 19;
	localparam int PW_MUL_W      = 16;
	localparam logic [PW_MUL_W-1:0] PW_MUL =
		PW_MUL_W'(((2 ** PW_SHIFT) + POWER_DIVISOR - 1) / POWER_DIVISOR);

	// running total and its average
	localparam int TOTAL_W   = $clog2(HISTORY_DEPTH * PW_MAX + 1);
	localparam int AVG_SHIFT = TOTAL_W + $clog2(HISTORY_DEPTH);
	localparam int AVG_MUL_W = TOTAL_W + 1;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL =
		AVG_MUL_W'(((2 ** AVG_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

	// speed: raw * 13 * 256 / 3600
	localparam int SPD_SHIFT = 24;
	localparam int SPD_MUL_W = 24;
	localparam logic [SPD_MUL_W-1:0] SPD_MUL =
		SPD_MUL_W'(((64'd1 << SPD_SHIFT) * 64'd3328 + 64'd3599) / 64'd3600);

	// power scale register
	localparam int SCALE_W = 9;
	localparam logic [SCALE_W-1:0] SCALE_MIN   = 9'd205;
	localparam logic [SCALE_W-1:0] SCALE_MAX   = 9'd307;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 9'd256;
	localparam int Q8_SHIFT = 8;

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_POWER_SCALE = '0;

	typedef struct packed {
		logic adv;   // pipeline moves this cycle
		logic upd;   // brake item at stage 2 updates the history
	} avg_ctl_t;

endpackage

[hdl/ttd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_rx_if / ttd_res_if
// byte channel and result channel of the decoder
// ----------------------------------------------------------------------------
interface ttd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source (output valid, rx_byte, last_byte, input ready);
	modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface ttd_res_if;
	import ttd_pkg::*;
	logic            valid;
	logic            ready;
	logic            controller_valid;
	logic            brake_valid;
	logic [7:0]      button_bits;
	logic [15:0]     steering_angle;
	logic [7:0]      heart_rate_bpm;
	logic [7:0]      cadence_rpm;
	logic [7:0]      pedal_active;
	logic [15:0]     speed_kph_q8;
	logic [PW_W-1:0] power_watts;

	modport source (output valid, controller_valid, brake_valid, button_bits,
		steering_angle, heart_rate_bpm, cadence_rpm, pedal_active, speed_kph_q8,
		power_watts, input ready);
	modport sink (input valid, controller_valid, brake_valid, button_bits,
		steering_angle, heart_rate_bpm, cadence_rpm, pedal_active, speed_kph_q8,
		power_watts, output ready);
endinterface

[hdl/ttd_power_avg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_power_avg
// power history ring in a synchronous memory with a running total
// ----------------------------------------------------------------------------
module ttd_power_avg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ttd_pkg::avg_ctl_t          ctl,
	input  logic [ttd_pkg::PW_W-1:0]   pw,
	output logic [ttd_pkg::TOTAL_W-1:0] total_s3
);
	import ttd_pkg::*;

	logic [PW_W-1:0]          mem [HISTORY_DEPTH];
	logic [PW_W-1:0]          rd_q;
	logic [HISTORY_DEPTH-1:0] vld_q;
	logic [HIST_IDX_W-1:0]    idx_q;
	logic [TOTAL_W-1:0]       tot_q;
	logic [PW_W-1:0]          old_pw;
	logic [TOTAL_W-1:0]       tot_nxt;
	logic                     wr;

	assign wr = ctl.adv && ctl.upd;

	// read ahead at the current slot; brake items are a message apart so the
	// read data has settled long before the next update
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (wr) begin
			mem[idx_q] <= pw;
		end
	end

	assign old_pw  = vld_q[idx_q] ? rd_q : '0;
	assign tot_nxt = tot_q + TOTAL_W'(pw) - TOTAL_W'(old_pw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			idx_q <= '0;
			tot_q <= '0;
		end else if (wr) begin
			vld_q[idx_q] <= 1'b1;
			tot_q        <= tot_nxt;
			if (idx_q == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			total_s3 <= ctl.upd ? tot_nxt : '0;
		end
	end

endmodule

[hdl/trainer_telemetry_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trainer_telemetry_decoder
// decodes trainer telemetry messages into controller and brake readings
// ----------------------------------------------------------------------------
// rx_chan takes one message byte per transfer, last_byte marks the end of a
// message; bytes past the message limit are dropped until the marked byte.
// res_chan gives one result per message, after stages 1 to 4 and the output
// register. one byte is taken every cycle unless a result waits untaken, also
// back to back with marked bytes; the only loop is the history update, which
// sits in one stage because the history memory is read ahead at the ring slot.
// brake power goes through a ring of the last ten brake messages in a
// one-port-write, registered-read memory; per-entry valid bits clear it at
// reset, so no clearing pass is needed.
// when the result receiver stalls, the whole pipeline holds and rx ready
// drops only while a result waits and is not taken.
// reset clears the byte counter, pipeline valids, the ring and the scale
// (256, unity). the scale is written over the apb port, clamped to 205..307.
// ----------------------------------------------------------------------------
module trainer_telemetry_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	ttd_rx_if.sink                         rx_chan,
	ttd_res_if.source                      res_chan,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ttd_pkg::PADDR_W-1:0]    paddr,
	input  logic [ttd_pkg::PDATA_W-1:0]    pwdata,
	output logic [ttd_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import ttd_pkg::*;

	// ---------------- register port ----------------
	logic [SCALE_W-1:0]   scale_q;
	logic [SCALE_W-1:0]   scale_in;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;
	assign scale_in = pwdata[SCALE_W-1:0];

	always_comb begin
		unique case (reg_idx)
			REG_POWER_SCALE: prdata = PDATA_W'(scale_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (reg_wr && reg_idx == REG_POWER_SCALE) begin
			// clamp to 0.8 .. 1.2
			if (scale_in < SCALE_MIN) begin
				scale_q <= SCALE_MIN;
			end else if (scale_in > SCALE_MAX) begin
				scale_q <= SCALE_MAX;
			end else begin
				scale_q <= scale_in;
			end
		end
	end

	// ---------------- flow control ----------------
	logic adv;      // every stage moves
	logic acc;      // byte transfer
	logic res_vld_q;

	assign adv           = !res_vld_q || res_chan.ready;
	assign rx_chan.ready = adv;
	assign acc           = rx_chan.valid && adv;

	// ---------------- byte capture ----------------
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       cap_hr_q, cap_btn_q, cap_cad_q, cap_ped_q;
	logic [15:0]      cap_st_q, cap_spd_q, cap_pwr_q;
	logic             len_ctrl, len_brake;

	// length so far including this byte, saturated at the message limit
	assign pos_inc   = (pos_q < POS_W'(MESSAGE_BYTES)) ? pos_q + 1'b1 : pos_q;
	assign len_ctrl  = pos_inc >= POS_W'(CONTROLLER_BYTES);
	assign len_brake = pos_inc >= POS_W'(BRAKE_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= rx_chan.last_byte ? '0 : pos_inc;
		end
	end

	// no captured byte sits at or past the length thresholds, so the marked
	// byte itself never feeds a field that is reported
	always_ff @(posedge clk) begin
		if (acc && pos_q < POS_W'(MESSAGE_BYTES)) begin
			case (pos_q)
				POS_HR:      cap_hr_q        <= rx_chan.rx_byte;
				POS_BTN:     cap_btn_q       <= rx_chan.rx_byte;
				POS_STEER_L: cap_st_q[7:0]   <= rx_chan.rx_byte;
				POS_STEER_H: cap_st_q[15:8]  <= rx_chan.rx_byte;
				POS_SPD_L:   cap_spd_q[7:0]  <= rx_chan.rx_byte;
				POS_SPD_H:   cap_spd_q[15:8] <= rx_chan.rx_byte;
				POS_PWR_L:   cap_pwr_q[7:0]  <= rx_chan.rx_byte;
				POS_PWR_H:   cap_pwr_q[15:8] <= rx_chan.rx_byte;
				POS_CAD:     cap_cad_q       <= rx_chan.rx_byte;
				POS_PEDAL:   cap_ped_q       <= rx_chan.rx_byte;
				default:     ;
			endcase
		end
	end

	// ---------------- stage 1: message snapshot ----------------
	logic        v_s1, ctrl_s1, brake_s1;
	logic [7:0]  btn_s1, hr_s1, cad_s1, ped_s1;
	logic [15:0] st_s1, spd_raw_s1, pwr_raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && rx_chan.last_byte;
		end
	end

	// fields of a short message read as zero
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1    <= len_ctrl;
			brake_s1   <= len_brake;
			btn_s1     <= len_ctrl  ? cap_btn_q : '0;
			st_s1      <= len_ctrl  ? cap_st_q  : '0;
			hr_s1      <= len_brake ? cap_hr_q  : '0;
			cad_s1     <= len_brake ? cap_cad_q : '0;
			ped_s1     <= len_brake ? cap_ped_q : '0;
			spd_raw_s1 <= len_brake ? cap_spd_q : '0;
			pwr_raw_s1 <= len_brake ? cap_pwr_q : '0;
		end
	end

	// ---------------- stage 2: power per message and speed ----------------
	logic [PW_MUL_W+14:0]        pw_prod;
	logic [PW_W-1:0]             pw_w;
	logic [SPD_MUL_W+15:0]       spd_prod;
	logic                        v_s2, ctrl_s2, brake_s2;
	logic [7:0]                  btn_s2, hr_s2, cad_s2, ped_s2;
	logic [15:0]                 st_s2, spd_s2;
	logic [PW_W-1:0]             pw_s2;

	// negative raw power clamps to zero
	assign pw_prod  = pwr_raw_s1[14:0] * PW_MUL;
	assign pw_w     = pwr_raw_s1[15] ? '0 : pw_prod[PW_SHIFT +: PW_W];
	assign spd_prod = spd_raw_s1 * SPD_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2  <= ctrl_s1;
			brake_s2 <= brake_s1;
			btn_s2   <= btn_s1;
			st_s2    <= st_s1;
			hr_s2    <= hr_s1;
			cad_s2   <= cad_s1;
			ped_s2   <= ped_s1;
			pw_s2    <= pw_w;
			spd_s2   <= spd_prod[SPD_SHIFT +: 16];
		end
	end

	// ---------------- stage 3: history ring and running total ----------------
	avg_ctl_t           avg_ctl;
	logic [TOTAL_W-1:0] total_s3;
	logic               v_s3, ctrl_s3, brake_s3;
	logic [7:0]         btn_s3, hr_s3, cad_s3, ped_s3;
	logic [15:0]        st_s3, spd_s3;

	assign avg_ctl.adv = adv;
	assign avg_ctl.upd = v_s2 && brake_s2;

	ttd_power_avg u_power_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (avg_ctl),
		.pw       (pw_s2),
		.total_s3 (total_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s3  <= ctrl_s2;
			brake_s3 <= brake_s2;
			btn_s3   <= btn_s2;
			st_s3    <= st_s2;
			hr_s3    <= hr_s2;
			cad_s3   <= cad_s2;
			ped_s3   <= ped_s2;
			spd_s3   <= spd_s2;
		end
	end

	// ---------------- stage 4: average over the ring ----------------
	logic [TOTAL_W+AVG_MUL_W-1:0] avg_prod;
	logic                         v_s4, ctrl_s4, brake_s4;
	logic [7:0]                   btn_s4, hr_s4, cad_s4, ped_s4;
	logic [15:0]                  st_s4, spd_s4;
	logic [PW_W-1:0]              avg_s4;

	assign avg_prod = total_s3 * AVG_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s4  <= ctrl_s3;
			brake_s4 <= brake_s3;
			btn_s4   <= btn_s3;
			st_s4    <= st_s3;
			hr_s4    <= hr_s3;
			cad_s4   <= cad_s3;
			ped_s4   <= ped_s3;
			spd_s4   <= spd_s3;
			avg_s4   <= avg_prod[AVG_SHIFT +: PW_W];
		end
	end

	// ---------------- output register: scaled power ----------------
	logic [PW_W+SCALE_W-1:0] pwr_prod;
	logic                    ctrl_q, brake_q;
	logic [7:0]              btn_q, hr_q, cad_q, ped_q;
	logic [15:0]             st_q, spd_q;
	logic [PW_W-1:0]         pwr_q;

	assign pwr_prod = avg_s4 * scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_q  <= ctrl_s4;
			brake_q <= brake_s4;
			btn_q   <= btn_s4;
			st_q    <= st_s4;
			hr_q    <= hr_s4;
			cad_q   <= cad_s4;
			ped_q   <= ped_s4;
			spd_q   <= spd_s4;
			pwr_q   <= pwr_prod[Q8_SHIFT +: PW_W];
		end
	end

	assign res_chan.valid            = res_vld_q;
	assign res_chan.controller_valid = ctrl_q;
	assign res_chan.brake_valid      = brake_q;
	assign res_chan.button_bits      = btn_q;
	assign res_chan.steering_angle   = st_q;
	assign res_chan.heart_rate_bpm   = hr_q;
	assign res_chan.cadence_rpm      = cad_q;
	assign res_chan.pedal_active     = ped_q;
	assign res_chan.speed_kph_q8     = spd_q;
	assign res_chan.power_watts      = pwr_q;

endmodule

[hdl/ttd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "trainer_telemetry_decoder_assert.svh"

module ttd_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rx_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic                     res_controller_valid,
	input logic                     res_brake_valid,
	input logic [15:0]              res_steering_angle,
	input logic [15:0]              res_speed_kph_q8,
	input logic [ttd_pkg::PW_W-1:0] res_power_watts
);
	import ttd_pkg::*;

	// a brake-length message is also controller length
	`TTD_ASSERT_SAME(a_brake_has_ctrl, res_valid && res_brake_valid, res_controller_valid, "brake result without controller flag")

	// short brake message gives zero speed and power
	`TTD_ASSERT_SAME(a_short_zero, res_valid && !res_brake_valid, res_speed_kph_q8 == '0 && res_power_watts == '0, "short message with brake values")

	// scaled average never exceeds max power times 1.2
	`TTD_ASSERT_SAME(a_power_max, res_valid, res_power_watts <= PW_W'(3022), "power above range")

	// the byte side is only held back by an untaken result
	`TTD_ASSERT_SAME(a_no_stall, res_ready || !res_valid, rx_ready, "byte side stalled without cause")

	// a stalled result holds
	`TTD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_steering_angle) && $stable(res_power_watts), "stalled result changed")

endmodule

bind trainer_telemetry_decoder ttd_checker u_ttd_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.rx_ready             (rx_chan.ready),
	.res_valid            (res_chan.valid),
	.res_ready            (res_chan.ready),
	.res_controller_valid (res_chan.controller_valid),
	.res_brake_valid      (res_chan.brake_valid),
	.res_steering_angle   (res_chan.steering_angle),
	.res_speed_kph_q8     (res_chan.speed_kph_q8),
	.res_power_watts      (res_chan.power_watts)
);
